@@ design/bmic_pkg.sv @@
package bmic_pkg;

    // Access kinds carried by an input beat
    localparam logic [2:0] KIND_CPU_RD = 3'd0;
    localparam logic [2:0] KIND_CPU_WR = 3'd1;
    localparam logic [2:0] KIND_PPU_RD = 3'd2;
    localparam logic [2:0] KIND_PPU_WR = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    // Memory targets reported in a result beat
    localparam logic [2:0] TGT_NONE = 3'd0;
    localparam logic [2:0] TGT_WRAM = 3'd1;
    localparam logic [2:0] TGT_PRG  = 3'd2;
    localparam logic [2:0] TGT_NT   = 3'd3;
    localparam logic [2:0] TGT_CHR  = 3'd4;

    // Mapper register groups, selected by address bits 15:12
    localparam logic [3:0] GRP_PRG_LO = 4'h8;
    localparam logic [3:0] GRP_PRG_HI = 4'h9;
    localparam logic [3:0] GRP_CHR_A  = 4'hA;
    localparam logic [3:0] GRP_CHR_B  = 4'hB;
    localparam logic [3:0] GRP_CHR_C  = 4'hC;
    localparam logic [3:0] GRP_CHR_D  = 4'hD;
    localparam logic [3:0] GRP_RELOAD = 4'hE;
    localparam logic [3:0] GRP_CTRL   = 4'hF;

    // Control group sub-registers, selected by address bits 1:0
    localparam logic [1:0] CTRL_ACK    = 2'd0;
    localparam logic [1:0] CTRL_MODE   = 2'd1;
    localparam logic [1:0] CTRL_MIRROR = 2'd2;
    localparam logic [1:0] CTRL_ADPCM  = 2'd3;

    // Mirroring codes
    localparam logic [1:0] MIR_HORZ = 2'd0;
    localparam logic [1:0] MIR_VERT = 2'd1;
    localparam logic [1:0] MIR_ONE0 = 2'd2;
    localparam logic [1:0] MIR_ONE1 = 2'd3;

    // Timer reload widths by counter mode; higher modes wrap instead
    localparam logic [2:0] TMR_RELOAD16 = 3'd0;
    localparam logic [2:0] TMR_RELOAD12 = 3'd1;
    localparam logic [2:0] TMR_RELOAD8  = 3'd2;
    localparam logic [2:0] TMR_RELOAD4  = 3'd3;

    // Configuration register indexes
    localparam logic CFG_PRG_COUNT   = 1'b0;
    localparam logic CFG_RAM_PRESENT = 1'b1;

    localparam logic [5:0] PRG_COUNT_RST = 6'd8;
    localparam logic       RAM_PRESENT_RST = 1'b1;

    localparam int PRG_BANKS = 3;
    localparam int CHR_BANKS = 8;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  target;
        logic [18:0] mapped_address;
        logic        irq_out;
    } t_out_item;

    // Bank and mirroring state seen by the address mapper
    typedef struct packed {
        logic [PRG_BANKS-1:0][5:0] prg_banks;
        logic [CHR_BANKS-1:0][7:0] chr_banks;
        logic [1:0]                mirror_mode;
    } t_map_state;

endpackage

@@ design/bank_mapper_with_irq_counter_core.sv @@
// Cartridge bank mapper with a down-counting interrupt timer. Each input beat
// is a CPU or PPU access or a timer tick; each gives exactly one result beat
// with the target memory, the address inside it and the interrupt level after
// the access. One beat is taken every cycle while the output side is ready: an
// input register and a result register hold the beats, and the bank decode and
// timer update sit between them, so a beat passes through the input register
// and then the result register. A stalled result holds the next beat in the
// input register and stops further beats from entering. Bank and timer state
// clear at reset to their power-on values; no clearing pass is needed.
module bank_mapper_with_irq_counter_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bmic_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bmic_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bmic_pkg::*;

    logic        r_s1_valid;
    t_in_item    r_s1_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [5:0]  r_prg_count;
    logic        r_ram_present;

    t_map_state  map_state;
    logic        irq_next;
    logic [2:0]  map_target;
    logic [18:0] map_addr;
    logic        step;
    logic        cfg_wr;

    // Advance the input beat when the result register is free
    assign step        = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || step;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    bmic_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_s1_item),
        .o_state     (map_state),
        .o_irq_level (irq_next)
    );

    bmic_map u_map (
        .i_item           (r_s1_item),
        .i_state          (map_state),
        .i_prg_count      (r_prg_count),
        .i_ram_present    (r_ram_present),
        .o_target         (map_target),
        .o_mapped_address (map_addr)
    );

    // Hold the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (step) begin
            r_out_item.target         <= map_target;
            r_out_item.mapped_address <= map_addr;
            r_out_item.irq_out        <= irq_next;
        end
    end

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count   <= PRG_COUNT_RST;
            r_ram_present <= RAM_PRESENT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_PRG_COUNT) begin
                r_prg_count <= pwdata[5:0];
            end else begin
                r_ram_present <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == CFG_PRG_COUNT) begin
            prdata = {26'd0, r_prg_count};
        end else begin
            prdata = {31'd0, r_ram_present};
        end
    end

    // No address leaks out with an open-bus result
    a_none_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.target == TGT_NONE |-> r_out_item.mapped_address == 19'd0)
        else $error("open-bus result carries an address");

    // An acknowledge or mode write drops the interrupt
    a_irq_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_s1_item.kind == KIND_CPU_WR && r_s1_item.address[15:12] == GRP_CTRL
        && (r_s1_item.address[1:0] == CTRL_ACK || r_s1_item.address[1:0] == CTRL_MODE)
        |=> r_out_item.irq_out == 1'b0)
        else $error("interrupt not cleared by acknowledge");

    // No work RAM result when the RAM is absent
    a_no_wram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && !r_ram_present |=> r_out_item.target != TGT_WRAM)
        else $error("work RAM targeted while absent");

endmodule

@@ design/bmic_regs.sv @@
module bmic_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  bmic_pkg::t_in_item  i_item,
    output bmic_pkg::t_map_state o_state,
    output logic                o_irq_level
);
    import bmic_pkg::*;

    logic [PRG_BANKS-1:0][5:0] r_prg_banks, n_prg_banks;
    logic [CHR_BANKS-1:0][7:0] r_chr_banks, n_chr_banks;
    logic        r_irq_level, n_irq_level;
    logic [15:0] r_irq_count, n_irq_count;
    logic [15:0] r_irq_reload, n_irq_reload;
    logic        r_irq_enabled, n_irq_enabled;
    logic [2:0]  r_irq_mode, n_irq_mode;
    logic [1:0]  r_mirror, n_mirror;

    logic [3:0] grp;
    logic [1:0] sub;
    logic [3:0] nib;
    logic [1:0] prg_idx;
    logic [3:0] chr_off;
    logic [2:0] chr_idx;
    logic       reg_wr;

    assign grp     = i_item.address[15:12];
    assign sub     = i_item.address[1:0];
    assign nib     = i_item.data[3:0];
    assign reg_wr  = (i_item.kind == KIND_CPU_WR) && i_item.address[15];
    assign prg_idx = (grp == GRP_PRG_LO) ? {1'b0, sub[1]} : 2'd2;
    assign chr_off = grp - GRP_CHR_A;
    assign chr_idx = {chr_off[1:0], sub[1]};

    // Decode register writes and advance the timer
    always_comb begin
        n_prg_banks   = r_prg_banks;
        n_chr_banks   = r_chr_banks;
        n_irq_level   = r_irq_level;
        n_irq_count   = r_irq_count;
        n_irq_reload  = r_irq_reload;
        n_irq_enabled = r_irq_enabled;
        n_irq_mode    = r_irq_mode;
        n_mirror      = r_mirror;
        if (reg_wr) begin
            unique case (grp)
                GRP_PRG_LO, GRP_PRG_HI: begin
                    if (grp == GRP_PRG_LO || !sub[1]) begin
                        if (sub[0]) begin
                            n_prg_banks[prg_idx][5:4] = i_item.data[1:0];
                        end else begin
                            n_prg_banks[prg_idx][3:0] = nib;
                        end
                    end
                end
                GRP_CHR_A, GRP_CHR_B, GRP_CHR_C, GRP_CHR_D: begin
                    if (sub[0]) begin
                        n_chr_banks[chr_idx][7:4] = nib;
                    end else begin
                        n_chr_banks[chr_idx][3:0] = nib;
                    end
                end
                GRP_RELOAD: begin
                    n_irq_reload[{sub, 2'b00} +: 4] = nib;
                end
                GRP_CTRL: begin
                    unique case (sub)
                        CTRL_ACK: begin
                            n_irq_count = r_irq_reload;
                            n_irq_level = 1'b0;
                        end
                        CTRL_MODE: begin
                            n_irq_enabled = i_item.data[0];
                            n_irq_mode    = i_item.data[3:1];
                            n_irq_level   = 1'b0;
                        end
                        CTRL_MIRROR: n_mirror = i_item.data[1:0];
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end else if (i_item.kind == KIND_TICK && r_irq_enabled) begin
            if (r_irq_count != 16'd0) begin
                n_irq_count = r_irq_count - 16'd1;
            end else begin
                n_irq_level = 1'b1;
                case (r_irq_mode)
                    TMR_RELOAD16: n_irq_count = r_irq_reload;
                    TMR_RELOAD12: n_irq_count = {4'd0, r_irq_reload[11:0]};
                    TMR_RELOAD8:  n_irq_count = {8'd0, r_irq_reload[7:0]};
                    TMR_RELOAD4:  n_irq_count = {12'd0, r_irq_reload[3:0]};
                    default:      n_irq_count = 16'hFFFF;
                endcase
            end
        end
    end

    // Commit state on each stepped beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PRG_BANKS; i++) r_prg_banks[i] <= 6'(i);
            for (int i = 0; i < CHR_BANKS; i++) r_chr_banks[i] <= 8'(i);
            r_irq_level   <= 1'b0;
            r_irq_count   <= 16'd0;
            r_irq_reload  <= 16'd0;
            r_irq_enabled <= 1'b0;
            r_irq_mode    <= 3'd0;
            r_mirror      <= MIR_HORZ;
        end else if (i_step) begin
            r_prg_banks   <= n_prg_banks;
            r_chr_banks   <= n_chr_banks;
            r_irq_level   <= n_irq_level;
            r_irq_count   <= n_irq_count;
            r_irq_reload  <= n_irq_reload;
            r_irq_enabled <= n_irq_enabled;
            r_irq_mode    <= n_irq_mode;
            r_mirror      <= n_mirror;
        end
    end

    assign o_state.prg_banks   = r_prg_banks;
    assign o_state.chr_banks   = r_chr_banks;
    assign o_state.mirror_mode = r_mirror;
    assign o_irq_level         = n_irq_level;

endmodule

@@ design/bmic_map.sv @@
module bmic_map (
    input  bmic_pkg::t_in_item   i_item,
    input  bmic_pkg::t_map_state i_state,
    input  logic [5:0]           i_prg_count,
    input  logic                 i_ram_present,
    output logic [2:0]           o_target,
    output logic [18:0]          o_mapped_address
);
    import bmic_pkg::*;

    logic [15:0] a;
    logic [5:0]  prg_bank;
    logic        nt_page;

    assign a = i_item.address;

    // Pick the program bank for the 8KB window
    always_comb begin
        case (a[14:13])
            2'd0:    prg_bank = i_state.prg_banks[0];
            2'd1:    prg_bank = i_state.prg_banks[1];
            2'd2:    prg_bank = i_state.prg_banks[2];
            default: prg_bank = i_prg_count - 6'd1;
        endcase
    end

    // Pick the name-table page from the mirroring mode
    always_comb begin
        case (i_state.mirror_mode)
            MIR_HORZ: nt_page = a[11];
            MIR_VERT: nt_page = a[10];
            MIR_ONE0: nt_page = 1'b0;
            default:  nt_page = 1'b1;
        endcase
    end

    // Route the access to its target memory
    always_comb begin
        o_target         = TGT_NONE;
        o_mapped_address = 19'd0;
        case (i_item.kind) inside
            KIND_CPU_RD, KIND_CPU_WR: begin
                if (a[15:13] == 3'b011) begin
                    if (i_ram_present) begin
                        o_target         = TGT_WRAM;
                        o_mapped_address = {6'd0, a[12:0]};
                    end
                end else if (a[15] && i_item.kind == KIND_CPU_RD) begin
                    o_target         = TGT_PRG;
                    o_mapped_address = {prg_bank, a[12:0]};
                end
            end
            KIND_PPU_RD, KIND_PPU_WR: begin
                if (a[13]) begin
                    o_target         = TGT_NT;
                    o_mapped_address = {8'd0, nt_page, a[9:0]};
                end else if (i_item.kind == KIND_PPU_RD) begin
                    o_target         = TGT_CHR;
                    o_mapped_address = {1'b0, i_state.chr_banks[a[12:10]], a[9:0]};
                end
            end
            default: ;
        endcase
    end

endmodule
